>>> sv/u8v_pkg.sv
`default_nettype none

package u8v_pkg;

  localparam int unsigned PosBits = 24;
  localparam int unsigned OutBits = 24;

  typedef logic [PosBits-1:0] pos_t;
  typedef logic [OutBits-1:0] out_pos_t;

  typedef enum logic [1:0] {
    StAccept = 2'd0,
    StNul    = 2'd1,
    StUtf    = 2'd2
  } status_e;

  localparam logic [7:0] ByteNewline = 8'h0A;
  localparam logic [7:0] ByteNul     = 8'h00;
  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContTag     = 8'h80;
  localparam logic [7:0] Lead2Lo     = 8'hC2;
  localparam logic [7:0] Lead2Hi     = 8'hDF;
  localparam logic [7:0] Lead3Lo     = 8'hE0;
  localparam logic [7:0] Lead3Hi     = 8'hEF;
  localparam logic [7:0] Lead4Lo     = 8'hF0;
  localparam logic [7:0] Lead4Hi     = 8'hF4;
  localparam logic [7:0] LeadSurr    = 8'hED;
  localparam logic [7:0] MinE0Cont   = 8'hA0;
  localparam logic [7:0] MaxEdCont   = 8'h9F;
  localparam logic [7:0] MinF0Cont   = 8'h90;
  localparam logic [7:0] MaxF4Cont   = 8'h8F;

  localparam pos_t PosMax = {PosBits{1'b1}};
  localparam logic [31:0] OutMax = 32'(OutBits'({OutBits{1'b1}}));

  typedef struct packed {
    pos_t       line;
    pos_t       bcol;
    pos_t       ccol;
    logic [1:0] pend;
    logic [2:0] swidth;
    logic [7:0] lead;
    logic       nul_seen;
    pos_t       nul_line;
    pos_t       nul_col;
    logic       utf_seen;
    pos_t       utf_line;
    pos_t       utf_col;
  } state_t;

  localparam state_t StateReset = '{
    line:     pos_t'(1),
    bcol:     pos_t'(1),
    ccol:     pos_t'(1),
    pend:     2'd0,
    swidth:   3'd0,
    lead:     8'd0,
    nul_seen: 1'b0,
    nul_line: pos_t'(0),
    nul_col:  pos_t'(0),
    utf_seen: 1'b0,
    utf_line: pos_t'(0),
    utf_col:  pos_t'(0)
  };

  function automatic pos_t sat_inc(pos_t v);
    return (v == PosMax) ? v : v + pos_t'(1);
  endfunction

  function automatic out_pos_t cap_out(pos_t v);
    logic [31:0] w;
    w = 32'(v);
    return (w > OutMax) ? out_pos_t'(OutMax) : out_pos_t'(w);
  endfunction

endpackage

`default_nettype wire

>>> sv/u8v_step.sv
`default_nettype none

module u8v_step
  import u8v_pkg::*;
(
  input  wire state_t     st_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       has_byte_i,
  input  wire logic       last_i,
  output state_t          st_o,
  output status_e         status_o,
  output out_pos_t        line_o,
  output out_pos_t        column_o
);

  state_t     s;
  logic       cont_ok;
  logic       first_cont;
  logic       range_bad;
  logic [1:0] pend_dec;

  assign cont_ok    = (data_byte_i & ContMask) == ContTag;
  assign first_cont = ({1'b0, st_i.pend} + 3'd1) == st_i.swidth;
  assign range_bad  = (st_i.lead == Lead3Lo  && data_byte_i < MinE0Cont) ||
                      (st_i.lead == LeadSurr && data_byte_i > MaxEdCont) ||
                      (st_i.lead == Lead4Lo  && data_byte_i < MinF0Cont) ||
                      (st_i.lead == Lead4Hi  && data_byte_i > MaxF4Cont);
  assign pend_dec   = st_i.pend - 2'd1;

  always_comb begin
    s        = st_i;
    status_o = StAccept;
    line_o   = '0;
    column_o = '0;

    if (has_byte_i) begin
      if (!st_i.utf_seen) begin
        if (st_i.pend == 2'd0) begin
          if (data_byte_i < ContTag) begin
            s.ccol = (data_byte_i == ByteNewline) ? pos_t'(1) : sat_inc(st_i.ccol);
          end else if (data_byte_i >= Lead2Lo && data_byte_i <= Lead2Hi) begin
            s.swidth = 3'd2;
            s.lead   = data_byte_i;
            s.pend   = 2'd1;
          end else if (data_byte_i >= Lead3Lo && data_byte_i <= Lead3Hi) begin
            s.swidth = 3'd3;
            s.lead   = data_byte_i;
            s.pend   = 2'd2;
          end else if (data_byte_i >= Lead4Lo && data_byte_i <= Lead4Hi) begin
            s.swidth = 3'd4;
            s.lead   = data_byte_i;
            s.pend   = 2'd3;
          end else begin
            s.utf_seen = 1'b1;
            s.utf_line = st_i.line;
            s.utf_col  = st_i.ccol;
          end
        end else if (!cont_ok || (first_cont && range_bad)) begin
          s.utf_seen = 1'b1;
          s.utf_line = st_i.line;
          s.utf_col  = st_i.ccol;
          s.pend     = 2'd0;
        end else begin
          s.pend = pend_dec;
          if (pend_dec == 2'd0) begin
            s.ccol = sat_inc(st_i.ccol);
          end
        end
      end

      if (!st_i.nul_seen && data_byte_i == ByteNul) begin
        s.nul_seen = 1'b1;
        s.nul_line = st_i.line;
        s.nul_col  = st_i.bcol;
      end

      if (data_byte_i == ByteNewline) begin
        s.line = sat_inc(st_i.line);
        s.bcol = pos_t'(1);
      end else begin
        s.bcol = sat_inc(st_i.bcol);
      end
    end

    if (last_i) begin
      // a sequence still open at the end is cut short
      if (!s.utf_seen && s.pend != 2'd0) begin
        s.utf_seen = 1'b1;
        s.utf_line = s.line;
        s.utf_col  = s.ccol;
      end
      if (s.nul_seen) begin
        status_o = StNul;
        line_o   = cap_out(s.nul_line);
        column_o = cap_out(s.nul_col);
      end else if (s.utf_seen) begin
        status_o = StUtf;
        line_o   = cap_out(s.utf_line);
        column_o = cap_out(s.utf_col);
      end
      s = StateReset;
    end

    st_o = s;
  end

endmodule

`default_nettype wire

>>> sv/utf8_nul_text_validator.sv
// Path: a byte with last passes the input register, then the result register;
//   bytes without last give no result. Position and sequence state is updated
//   combinationally. Throughput: one byte per cycle while no last item waits
//   on a held result; a waiting result does not stall bytes without last.
// Reset: asynchronous; counters return to 1 and all flags clear at once.
`default_nettype none

module utf8_nul_text_validator
  import u8v_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       has_byte_i,
  input  wire logic       last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      status_o,
  output logic [23:0]     err_line_o,
  output logic [23:0]     error_column_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_has_q;
  logic       s1_last_q;
  logic       out_free;
  logic       s1_adv;

  state_t   st_q;
  state_t   st_d;
  status_e  res_status;
  out_pos_t res_line;
  out_pos_t res_col;

  logic       out_valid_q;
  logic [1:0] status_q;
  out_pos_t   line_q;
  out_pos_t   col_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= data_byte_i;
      s1_has_q  <= has_byte_i;
      s1_last_q <= last_i;
    end
  end

  u8v_step u_step (
    .st_i        (st_q),
    .data_byte_i (s1_byte_q),
    .has_byte_i  (s1_has_q),
    .last_i      (s1_last_q),
    .st_o        (st_d),
    .status_o    (res_status),
    .line_o      (res_line),
    .column_o    (res_col)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else if (s1_adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // load the result only when the item with last leaves the input register
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      status_q <= res_status;
      line_q   <= res_line;
      col_q    <= res_col;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign err_line_o     = line_q;
  assign error_column_o = col_q;

  a_accept_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StAccept |-> err_line_o == '0 && error_column_o == '0)
    else $error("accepted text reports a nonzero position");

  a_error_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StNul || status_o == StUtf)
      |-> err_line_o != '0 && error_column_o != '0)
    else $error("error reported at position zero");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == StAccept || status_o == StNul || status_o == StUtf)
    else $error("illegal status code");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> st_q.pend == 2'd0 && !st_q.nul_seen && !st_q.utf_seen
      && st_q.line == pos_t'(1) && st_q.bcol == pos_t'(1) && st_q.ccol == pos_t'(1))
    else $error("state not cleared after end of text");

  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !(s1_adv && s1_last_q))
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire

>>> verif/text_verdict_checker.sv
module text_verdict_checker
  import u8v_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        last_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [1:0]  status_i,
  input  wire logic [23:0] err_line_i,
  input  wire logic [23:0] error_column_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ShownMismatches = 10;

  typedef struct packed {
    status_e  status;
    out_pos_t line;
    out_pos_t col;
  } verdict_t;

  verdict_t verdict_q[$];
  int       fails = 0;
  int       results = 0;

  // predicted text state
  pos_t       line_n = pos_t'(1);
  pos_t       bcol_n = pos_t'(1);
  pos_t       ccol_n = pos_t'(1);
  logic [1:0] pend_n = '0;
  logic [2:0] seq_width = '0;
  logic [7:0] seq_lead = '0;
  logic       nul_found = 1'b0;
  pos_t       nul_line = '0;
  pos_t       nul_col = '0;
  logic       bad_found = 1'b0;
  pos_t       bad_line = '0;
  pos_t       bad_col = '0;

  function automatic pos_t bump(pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  task automatic clear_text();
    line_n    = pos_t'(1);
    bcol_n    = pos_t'(1);
    ccol_n    = pos_t'(1);
    pend_n    = '0;
    seq_width = '0;
    seq_lead  = '0;
    nul_found = 1'b0;
    nul_line  = '0;
    nul_col   = '0;
    bad_found = 1'b0;
    bad_line  = '0;
    bad_col   = '0;
  endtask

  task automatic mark_bad_sequence();
    bad_found = 1'b1;
    bad_line  = line_n;
    bad_col   = ccol_n;
    pend_n    = '0;
  endtask

  task automatic open_sequence(input logic [7:0] b, input int width);
    seq_width = 3'(width);
    seq_lead  = b;
    pend_n    = 2'(width - 1);
  endtask

  task automatic decode_utf8(input logic [7:0] b);
    logic range_bad;
    if (pend_n == '0) begin
      if (b < ContTag) begin
        ccol_n = (b == ByteNewline) ? pos_t'(1) : bump(ccol_n);
      end else if (b >= Lead2Lo && b <= Lead2Hi) begin
        open_sequence(b, 2);
      end else if (b >= Lead3Lo && b <= Lead3Hi) begin
        open_sequence(b, 3);
      end else if (b >= Lead4Lo && b <= Lead4Hi) begin
        open_sequence(b, 4);
      end else begin
        mark_bad_sequence();
      end
    end else if ((b & ContMask) != ContTag) begin
      mark_bad_sequence();
    end else begin
      // only the first continuation is range-limited
      range_bad = (int'(pend_n) + 1 == int'(seq_width)) &&
                  ((seq_lead == Lead3Lo  && b < MinE0Cont) ||
                   (seq_lead == LeadSurr && b > MaxEdCont) ||
                   (seq_lead == Lead4Lo  && b < MinF0Cont) ||
                   (seq_lead == Lead4Hi  && b > MaxF4Cont));
      if (range_bad) begin
        mark_bad_sequence();
      end else begin
        pend_n = pend_n - 2'd1;
        if (pend_n == '0) ccol_n = bump(ccol_n);
      end
    end
  endtask

  task automatic absorb_item(input logic [7:0] b, input logic hb, input logic fin);
    verdict_t v;
    if (hb) begin
      if (!bad_found) decode_utf8(b);
      if (!nul_found && b == ByteNul) begin
        nul_found = 1'b1;
        nul_line  = line_n;
        nul_col   = bcol_n;
      end
      if (b == ByteNewline) begin
        line_n = bump(line_n);
        bcol_n = pos_t'(1);
      end else begin
        bcol_n = bump(bcol_n);
      end
    end
    if (fin) begin
      // a sequence still open at the end is truncated
      if (!bad_found && pend_n != '0) mark_bad_sequence();
      if (nul_found) begin
        v = '{StNul, out_pos_t'(nul_line), out_pos_t'(nul_col)};
      end else if (bad_found) begin
        v = '{StUtf, out_pos_t'(bad_line), out_pos_t'(bad_col)};
      end else begin
        v = '{StAccept, '0, '0};
      end
      verdict_q.push_back(v);
      clear_text();
    end
  endtask

  task automatic note_failure(input string what, input verdict_t want);
    fails++;
    if (fails <= ShownMismatches) begin
      $display("[%0t] %s: expected status %0d line %0d col %0d, got status %0d line %0d col %0d",
               $realtime, what, want.status, want.line, want.col,
               status_i, err_line_i, error_column_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      verdict_q.delete();
      clear_text();
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results++;
        if (verdict_q.size() == 0) begin
          note_failure("result with nothing expected", '0);
        end else begin
          want = verdict_q.pop_front();
          if (status_i !== want.status || err_line_i !== want.line ||
              error_column_i !== want.col) begin
            note_failure("result mismatch", want);
          end
        end
      end
      if (in_valid_i && in_ready_i) absorb_item(data_byte_i, has_byte_i, last_i);
      fail_count_o <= fails;
      pending_o    <= verdict_q.size();
      results_o    <= results;
    end
  end

endmodule

>>> verif/tb.sv
module tb;
  import u8v_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 1300;
  localparam int HoldCycles  = 300;
  localparam int LimitCycles = 200000;

  typedef struct packed {
    logic [7:0] b;
    logic       h;
    logic       l;
  } byte_item_t;

  logic        clk_i;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last_item;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [23:0] err_line;
  logic [23:0] error_column;

  int fail_count;
  int pending;
  int results;

  logic calm = 1'b0;
  int   holds_asked = 0;
  int   holds_served = 0;

  byte_item_t text_q[$];
  int texts = 0;
  int items_sent = 0;
  int gaps_sent = 0;

  utf8_nul_text_validator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .data_byte_i   (data_byte),
    .has_byte_i    (has_byte),
    .last_i        (last_item),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .err_line_o    (err_line),
    .error_column_o(error_column)
  );

  text_verdict_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .data_byte_i   (data_byte),
    .has_byte_i    (has_byte),
    .last_i        (last_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .err_line_i    (err_line),
    .error_column_i(error_column),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(LimitCycles * 12);
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin : rx_side
    int k;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_asked) begin
        out_ready <= 1'b0;
        for (k = 0; k < HoldCycles; k++) @(posedge clk_i);
        holds_served++;
      end else begin
        out_ready <= rst_n && (calm || $urandom_range(99) >= 24);
      end
    end
  end

  function automatic logic [7:0] cont(input logic [7:0] lo, input logic [7:0] hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic put(input logic [7:0] b);
    text_q.push_back('{b, 1'b1, 1'b0});
  endtask

  task automatic put_gap();
    text_q.push_back('{8'($urandom), 1'b0, 1'b0});
  endtask

  task automatic offer(input byte_item_t it);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    data_byte <= it.b;
    has_byte  <= it.h;
    last_item <= it.l;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // close the text with last on its final byte or with a separate end marker
  task automatic send_text(input bit end_marker);
    if (end_marker || text_q.size() == 0) begin
      text_q.push_back('{8'($urandom), 1'b0, 1'b1});
    end else begin
      text_q[text_q.size() - 1].l = 1'b1;
    end
    foreach (text_q[i]) begin
      offer(text_q[i]);
      if (text_q[i].h || text_q[i].l) items_sent++;
      else gaps_sent++;
    end
    text_q.delete();
    texts++;
  endtask

  task automatic add_char();
    int unsigned k;
    logic [7:0]  lead;
    k = $urandom_range(99);
    if (k < 40) begin
      put(8'($urandom_range(8'h7F, 8'h01)));
    end else if (k < 48) begin
      put(ByteNewline);
    end else if (k < 63) begin
      put(cont(Lead2Lo, Lead2Hi));
      put(cont(ContTag, 8'hBF));
    end else if (k < 83) begin
      lead = cont(Lead3Lo, Lead3Hi);
      put(lead);
      if (lead == Lead3Lo) put(cont(MinE0Cont, 8'hBF));
      else if (lead == LeadSurr) put(cont(ContTag, MaxEdCont));
      else put(cont(ContTag, 8'hBF));
      put(cont(ContTag, 8'hBF));
    end else begin
      lead = cont(Lead4Lo, Lead4Hi);
      put(lead);
      if (lead == Lead4Lo) put(cont(MinF0Cont, 8'hBF));
      else if (lead == Lead4Hi) put(cont(ContTag, MaxF4Cont));
      else put(cont(ContTag, 8'hBF));
      put(cont(ContTag, 8'hBF));
      put(cont(ContTag, 8'hBF));
    end
  endtask

  task automatic add_flaw();
    case ($urandom_range(10))
      0: put(8'($urandom));
      1: put(($urandom_range(3) == 0) ? cont(8'hC0, 8'hC1) : cont(8'hF5, 8'hFF));
      2: put(cont(ContTag, 8'hBF));
      3: begin
        put(Lead3Lo);
        put(cont(ContTag, 8'h9F));
      end
      4: begin
        put(LeadSurr);
        put(cont(MinE0Cont, 8'hBF));
      end
      5: begin
        put(Lead4Lo);
        put(cont(ContTag, MaxF4Cont));
      end
      6: begin
        put(Lead4Hi);
        put(cont(MinF0Cont, 8'hBF));
      end
      7, 8: put(ByteNul);
      9: begin
        // open sequence left short
        put(cont(Lead3Lo, Lead4Hi));
        if ($urandom_range(1)) put(cont(ContTag, 8'hBF));
      end
      default: begin
        put(cont(Lead2Lo, Lead2Hi));
        put(cont(8'h00, 8'h7F));
      end
    endcase
  endtask

  task automatic random_text(input int flaw_pct);
    int n;
    n = ($urandom_range(19) == 0) ? 0 : $urandom_range(8, 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < flaw_pct) add_flaw();
      else add_char();
      if ($urandom_range(99) < 4) put_gap();
    end
    send_text($urandom_range(4) == 0);
  endtask

  // pause the sender until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int target;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    data_byte <= '0;
    has_byte  <= 1'b0;
    last_item <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // empty text
    send_text(1'b1);
    // NUL on the second line
    put("a"); put(ByteNewline); put(ByteNul);
    send_text(1'b0);
    // overlong three-byte form
    put(Lead3Lo); put(8'h9F);
    send_text(1'b0);
    // surrogate
    put(LeadSurr); put(MinE0Cont); put(ContTag);
    send_text(1'b0);
    // above U+10FFFF
    put(Lead4Hi); put(MinF0Cont); put(ContTag); put(ContTag);
    send_text(1'b0);
    // overlong four-byte form
    put(Lead4Lo); put(MaxF4Cont);
    send_text(1'b0);
    // bad leads and a lone continuation, one text each
    put(8'hC0);
    send_text(1'b0);
    put(8'hFF);
    send_text(1'b0);
    put(ContTag);
    send_text(1'b0);
    // truncated at the end, with an empty item in between
    put(8'hE2); put(8'h82); put_gap();
    send_text(1'b1);
    // largest code point, accepted
    put(Lead4Hi); put(MaxF4Cont); put(8'hBF); put(8'hBF);
    send_text(1'b0);
    drain();

    target = items_sent + RandomItems / 2;
    while (items_sent < target) random_text(6);
    drain();

    // hold the receiver off while short texts keep arriving
    calm <= 1'b1;
    holds_asked <= holds_asked + 1;
    repeat (40) begin
      put(8'($urandom));
      send_text(1'b0);
    end
    drain();

    // no idling on either side for a while
    target = items_sent + RandomItems / 4;
    while (items_sent < target) random_text(5);
    calm <= 1'b0;

    target = items_sent + RandomItems / 4;
    while (items_sent < target) random_text(8);

    in_valid <= 1'b0;
    drain();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d texts: %0d byte and end items, %0d empty items, %0d results checked",
             texts, items_sent, gaps_sent, results);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
